>>> design/pse_pkg.sv
// Shared types, codes and default sizes of the postfix stack evaluator.
package pse_pkg;

   // Default sizes handed to the top level parameters
   localparam int STACK_DEPTH_DEF = 32;
   localparam int DATA_WIDTH_DEF  = 32;

   // Fixed field widths of the request and response words
   localparam int NUMBER_W    = 32;
   localparam int OPERATION_W = 3;
   localparam int TOP_VALUE_W = 32;
   localparam int DEPTH_W     = 6;
   localparam int STATUS_W    = 2;

   // Token kinds
   localparam logic KIND_NUMBER   = 1'b0;
   localparam logic KIND_OPERATOR = 1'b1;

   // Operator codes
   localparam logic [OPERATION_W-1:0] OP_ADD = 3'd0;
   localparam logic [OPERATION_W-1:0] OP_SUB = 3'd1;
   localparam logic [OPERATION_W-1:0] OP_MUL = 3'd2;
   localparam logic [OPERATION_W-1:0] OP_DIV = 3'd3;
   localparam logic [OPERATION_W-1:0] OP_POW = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd3;

   // Command from the sequencer to the iterative arithmetic unit
   typedef struct packed {
      logic                   start;
      logic [OPERATION_W-1:0] op;
   } alu_cmd_type;

endpackage

>>> design/pse_if.sv
// Request and response channel interfaces of the postfix stack evaluator.
interface pse_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [pse_pkg::NUMBER_W-1:0] number;
   logic [pse_pkg::OPERATION_W-1:0]     operation;
   logic                                start_req;

   modport source (output valid, kind, number, operation, start_req, input ready);
   modport sink   (input valid, kind, number, operation, start_req, output ready);
endinterface

interface pse_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pse_pkg::TOP_VALUE_W-1:0] top_value;
   logic [pse_pkg::DEPTH_W-1:0]            depth;
   logic [pse_pkg::STATUS_W-1:0]           status;

   modport source (output valid, top_value, depth, status, input ready);
   modport sink   (input valid, top_value, depth, status, output ready);
endinterface

>>> design/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: sequencer, stack RAM and output register.
//
// Usage: each request word carries one postfix token. A number token pushes
// its value; an operator token pops two values and pushes the result
// (add, subtract, multiply, truncating divide, power), wrapping at
// DATA_WIDTH bits. start_req empties the stack before the token. Each
// request gives exactly one response word: top value (0 when empty), depth
// and status (ok, too few operands, stack full, divide by zero); on an
// error the stack is left as it was.
// Timing: a push, a stack error or an unknown operator goes from accept straight
// to the response; add and subtract pass through operand fetch and execute;
// multiply, divide (one quotient bit per cycle) and power then wait on the
// iterative unit, power with one pass per significant exponent bit, none for a negative exponent.
// The next request is taken once the previous response has been loaded into
// the output register, so at most one token is in flight. The left operand
// is read from the stack RAM through its registered read port; the top value
// is held in a register. Reset empties the stack at once, without a clearing
// pass. A stalled response holds in the output register and blocks the next
// result.
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = pse_pkg::DATA_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   pse_req_if.sink   req,
   pse_rsp_if.source rsp
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  depth_ff, depth_in;
   logic [DATA_WIDTH-1:0]             top_ff, top_in;
   logic [pse_pkg::OPERATION_W-1:0]   op_ff, op_in;
   logic [pse_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pse_pkg::TOP_VALUE_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [pse_pkg::DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   logic [pse_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [CNT_W-1:0]      depth_eff;
   logic [CNT_W-1:0]      depth_m2;
   logic [63:0]           num_ext;
   logic [63:0]           top_ext;
   logic [DATA_WIDTH-1:0] num_dw;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;
   pse_pkg::alu_cmd_type  alu_cmd;
   logic                  alu_done;
   logic [DATA_WIDTH-1:0] alu_result;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // Effective depth after an optional start, and the left operand slot
   assign depth_eff = req.start_req ? '0 : depth_ff;
   assign depth_m2  = depth_ff - CNT_W'(2);

   // Sign-extend the pushed number, then fit it to the stack width
   assign num_ext = 64'(req.number);
   assign num_dw  = num_ext[DATA_WIDTH-1:0];
   assign top_ext = 64'(signed'(top_ff));

   assign rd_en = (state_ff == S_FETCH);

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = depth_m2[ADDR_W-1:0];
      wr_data       = alu_result;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = op_ff;

      // Drop the response word once taken
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               depth_in  = depth_eff;
               op_in     = req.operation;
               status_in = pse_pkg::ST_OK;
               state_in  = S_RESP;
               if (req.kind == pse_pkg::KIND_NUMBER) begin
                  if (depth_eff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = pse_pkg::ST_FULL;
                  end else begin
                     // Push the number
                     wr_en    = 1'b1;
                     wr_addr  = depth_eff[ADDR_W-1:0];
                     wr_data  = num_dw;
                     top_in   = num_dw;
                     depth_in = depth_eff + CNT_W'(1);
                  end
               end else if (req.operation <= pse_pkg::OP_POW) begin
                  if (depth_eff < CNT_W'(2)) begin
                     status_in = pse_pkg::ST_FEW;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // Left operand is in rd_data, right operand is the top register
            case (op_ff) inside
               pse_pkg::OP_ADD,
               pse_pkg::OP_SUB: begin
                  wr_en    = 1'b1;
                  wr_data  = (op_ff == pse_pkg::OP_ADD) ? (rd_data + top_ff)
                                                         : (rd_data - top_ff);
                  top_in   = wr_data;
                  depth_in = depth_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
               pse_pkg::OP_DIV: begin
                  if (top_ff == '0) begin
                     status_in = pse_pkg::ST_DIVZ;
                     state_in  = S_RESP;
                  end else begin
                     alu_cmd.start = 1'b1;
                     state_in      = S_WAIT;
                  end
               end
               default: begin
                  alu_cmd.start = 1'b1;
                  state_in      = S_WAIT;
               end
            endcase
         end
         S_WAIT: begin
            // Commit the result of the iterative unit
            if (alu_done) begin
               wr_en    = 1'b1;
               top_in   = alu_result;
               depth_in = depth_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Load the response word when the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (depth_ff == '0) ? '0 : top_ext[pse_pkg::TOP_VALUE_W-1:0];
               rsp_depth_in  = pse_pkg::DEPTH_W'(depth_ff);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      op_ff         <= op_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.top_value = rsp_top_ff;
   assign rsp.depth     = rsp_depth_ff;
   assign rsp.status    = rsp_status_ff;

   pse_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   pse_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .lhs    (rd_data),
      .rhs    (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

endmodule

>>> design/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pse_alu.sv
// Iterative multiply, divide and power unit of the postfix stack evaluator.
module pse_alu #(
   parameter int DATA_WIDTH = pse_pkg::DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pse_pkg::alu_cmd_type cmd,
   input  logic [DATA_WIDTH-1:0] lhs,
   input  logic [DATA_WIDTH-1:0] rhs,
   output logic                 done,
   output logic [DATA_WIDTH-1:0] result
);

   // Multiplier digit size and step count
   localparam int MUL_CHUNK = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
   localparam int MUL_STEPS = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int CNT_W     = $clog2(DATA_WIDTH);

   localparam logic [2:0] A_IDLE    = 3'd0;
   localparam logic [2:0] A_MUL     = 3'd1;
   localparam logic [2:0] A_DIV     = 3'd2;
   localparam logic [2:0] A_DIV_FIX = 3'd3;
   localparam logic [2:0] A_POW_BIT = 3'd4;
   localparam logic [2:0] A_POW_MUL = 3'd5;

   logic [2:0]            phase_ff, phase_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] base_ff, base_in;
   logic [DATA_WIDTH-1:0] exp_ff, exp_in;
   logic [DATA_WIDTH-1:0] mcand1_ff, mcand1_in;
   logic [DATA_WIDTH-1:0] mcand2_ff, mcand2_in;
   logic [DATA_WIDTH-1:0] mplier_ff, mplier_in;
   logic [DATA_WIDTH-1:0] sum1_ff, sum1_in;
   logic [DATA_WIDTH-1:0] sum2_ff, sum2_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvsr_ff, dvsr_in;
   logic                  neg_ff, neg_in;

   logic [MUL_CHUNK-1:0]  chunk;
   logic [DATA_WIDTH-1:0] prod1, prod2;
   logic [DATA_WIDTH:0]   trial, diff;
   logic                  last_mul;

   // One multiplier digit against both multiplicands
   assign chunk    = mplier_ff[MUL_CHUNK-1:0];
   assign prod1    = mcand1_ff * DATA_WIDTH'(chunk);
   assign prod2    = mcand2_ff * DATA_WIDTH'(chunk);
   assign last_mul = (cnt_ff == CNT_W'(MUL_STEPS - 1));

   // One restoring division step
   assign trial = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      mcand1_in = mcand1_ff;
      mcand2_in = mcand2_ff;
      mplier_in = mplier_ff;
      sum1_in   = sum1_ff;
      sum2_in   = sum2_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvsr_in   = dvsr_ff;
      neg_in    = neg_ff;

      unique case (phase_ff)
         A_IDLE: begin
            if (cmd.start) begin
               cnt_in = '0;
               case (cmd.op)
                  pse_pkg::OP_MUL: begin
                     mcand1_in = lhs;
                     mplier_in = rhs;
                     sum1_in   = '0;
                     phase_in  = A_MUL;
                  end
                  pse_pkg::OP_DIV: begin
                     // Divide magnitudes, fix the sign at the end
                     quo_in   = lhs[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - lhs) : lhs;
                     dvsr_in  = rhs[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - rhs) : rhs;
                     rem_in   = '0;
                     neg_in   = lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
                     phase_in = A_DIV;
                  end
                  default: begin
                     // Power: a negative exponent gives one
                     if (rhs[DATA_WIDTH-1]) begin
                        result_in = DATA_WIDTH'(1);
                        done_in   = 1'b1;
                     end else begin
                        acc_in   = DATA_WIDTH'(1);
                        base_in  = lhs;
                        exp_in   = rhs;
                        phase_in = A_POW_BIT;
                     end
                  end
               endcase
            end
         end
         A_MUL: begin
            sum1_in   = sum1_ff + prod1;
            mcand1_in = mcand1_ff << MUL_CHUNK;
            mplier_in = mplier_ff >> MUL_CHUNK;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (last_mul) begin
               result_in = sum1_ff + prod1;
               done_in   = 1'b1;
               phase_in  = A_IDLE;
            end
         end
         A_DIV: begin
            if (!diff[DATA_WIDTH]) begin
               rem_in = diff;
            end else begin
               rem_in = trial;
            end
            quo_in = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               phase_in = A_DIV_FIX;
            end
         end
         A_DIV_FIX: begin
            result_in = neg_ff ? (DATA_WIDTH'(0) - quo_ff) : quo_ff;
            done_in   = 1'b1;
            phase_in  = A_IDLE;
         end
         A_POW_BIT: begin
            // Square the base and multiply the accumulator in parallel
            if (exp_ff == '0) begin
               result_in = acc_ff;
               done_in   = 1'b1;
               phase_in  = A_IDLE;
            end else begin
               mcand1_in = acc_ff;
               mcand2_in = base_ff;
               mplier_in = base_ff;
               sum1_in   = '0;
               sum2_in   = '0;
               cnt_in    = '0;
               phase_in  = A_POW_MUL;
            end
         end
         A_POW_MUL: begin
            sum1_in   = sum1_ff + prod1;
            sum2_in   = sum2_ff + prod2;
            mcand1_in = mcand1_ff << MUL_CHUNK;
            mcand2_in = mcand2_ff << MUL_CHUNK;
            mplier_in = mplier_ff >> MUL_CHUNK;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (last_mul) begin
               if (exp_ff[0]) begin
                  acc_in = sum1_ff + prod1;
               end
               base_in  = sum2_ff + prod2;
               exp_in   = exp_ff >> 1;
               phase_in = A_POW_BIT;
            end
         end
         default: begin
            phase_in = A_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      mcand1_ff <= mcand1_in;
      mcand2_ff <= mcand2_in;
      mplier_ff <= mplier_in;
      sum1_ff   <= sum1_in;
      sum2_ff   <= sum2_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvsr_ff   <= dvsr_in;
      neg_ff    <= neg_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> tb/sv/postfix_stack_evaluator_tb.sv
// Self-checking testbench of the postfix stack evaluator: token driver, result monitor, predictor.
module postfix_stack_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STK_N          = pse_pkg::STACK_DEPTH_DEF;
   localparam int TOKEN_TARGET   = 700;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 120;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      logic                            kind;
      logic [pse_pkg::NUMBER_W-1:0]    number;
      logic [pse_pkg::OPERATION_W-1:0] operation;
      logic                            start_req;
   } token_type;

   typedef struct {
      logic [pse_pkg::TOP_VALUE_W-1:0] top_value;
      logic [pse_pkg::DEPTH_W-1:0]     depth;
      logic [pse_pkg::STATUS_W-1:0]    status;
   } stack_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pse_req_if req ();
   pse_rsp_if rsp ();

   postfix_stack_evaluator DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   token_type      token_q[$];
   stack_view_type result_q[$];
   int             token_total = 0;
   int             req_count   = 0;
   int             rsp_count   = 0;
   int             fail_count  = 0;
   int             idle_cycles = 0;
   int             gen_depth   = 0;
   logic           word_taken  = 1'b0;

   // Shadow of the operand stack
   logic [pse_pkg::NUMBER_W-1:0] shadow_stack [STK_N];
   int                           shadow_depth = 0;

   // Truncating signed divide through magnitudes; most negative / -1 wraps
   function automatic logic [pse_pkg::NUMBER_W-1:0] trunc_quotient(
         logic [pse_pkg::NUMBER_W-1:0] a, logic [pse_pkg::NUMBER_W-1:0] b);
      logic [pse_pkg::NUMBER_W-1:0] ma, mb, q;
      ma = a[pse_pkg::NUMBER_W-1] ? -a : a;
      mb = b[pse_pkg::NUMBER_W-1] ? -b : b;
      q  = ma / mb;
      if (a[pse_pkg::NUMBER_W-1] ^ b[pse_pkg::NUMBER_W-1])
         q = -q;
      return q;
   endfunction

   // Square-and-multiply with wrap; a negative exponent gives 1
   function automatic logic [pse_pkg::NUMBER_W-1:0] power_mod(
         logic [pse_pkg::NUMBER_W-1:0] b, logic [pse_pkg::NUMBER_W-1:0] e);
      logic [pse_pkg::NUMBER_W-1:0] acc;
      acc = 1;
      if (e[pse_pkg::NUMBER_W-1])
         return 1;
      while (e != 0) begin
         if (e[0])
            acc = acc * b;
         b = b * b;
         e = e >> 1;
      end
      return acc;
   endfunction

   // Apply one token to the shadow stack and return the stack view it leaves
   function automatic stack_view_type eval_token(token_type t);
      logic [pse_pkg::NUMBER_W-1:0] lhs, rhs, res;
      logic [pse_pkg::STATUS_W-1:0] st;
      logic                         apply;
      stack_view_type               v;
      st    = pse_pkg::ST_OK;
      apply = 1'b1;
      res   = '0;
      if (t.start_req)
         shadow_depth = 0;
      if (t.kind == pse_pkg::KIND_NUMBER) begin
         if (shadow_depth >= STK_N) begin
            st = pse_pkg::ST_FULL;
         end else begin
            shadow_stack[shadow_depth] = t.number;
            shadow_depth++;
         end
      end else if (t.operation <= pse_pkg::OP_POW) begin
         if (shadow_depth < 2) begin
            st = pse_pkg::ST_FEW;
         end else begin
            lhs = shadow_stack[shadow_depth-2];
            rhs = shadow_stack[shadow_depth-1];
            case (t.operation)
               pse_pkg::OP_ADD: res = lhs + rhs;
               pse_pkg::OP_SUB: res = lhs - rhs;
               pse_pkg::OP_MUL: res = lhs * rhs;
               pse_pkg::OP_DIV: begin
                  if (rhs == 0) begin
                     apply = 1'b0;
                     st    = pse_pkg::ST_DIVZ;
                  end else begin
                     res = trunc_quotient(lhs, rhs);
                  end
               end
               default: res = power_mod(lhs, rhs);
            endcase
            if (apply) begin
               shadow_depth--;
               shadow_stack[shadow_depth-1] = res;
            end
         end
      end
      v.top_value = (shadow_depth != 0) ? shadow_stack[shadow_depth-1] : '0;
      v.depth     = shadow_depth[pse_pkg::DEPTH_W-1:0];
      v.status    = st;
      return v;
   endfunction

   // Queue one token and track the rough depth the generator aims for
   task automatic add_token(input logic kind, input logic [pse_pkg::NUMBER_W-1:0] number,
                            input logic [pse_pkg::OPERATION_W-1:0] operation,
                            input logic start_req);
      token_type t;
      t.kind      = kind;
      t.number    = number;
      t.operation = operation;
      t.start_req = start_req;
      token_q.push_back(t);
      if (start_req)
         gen_depth = 0;
      if (kind == pse_pkg::KIND_NUMBER) begin
         if (gen_depth < STK_N)
            gen_depth++;
      end else if (operation <= pse_pkg::OP_POW && gen_depth >= 2) begin
         gen_depth--;
      end
   endtask

   // Operand values: 40% small, 10% extremes, the rest full range
   function automatic logic [pse_pkg::NUMBER_W-1:0] rand_value();
      case ($urandom_range(0, 9)) inside
         0, 1, 2, 3: return $urandom_range(0, 16) - 8;
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'h0000_0000;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Random operator code from zero up to a bound
   function automatic logic [pse_pkg::OPERATION_W-1:0] rand_op(int unsigned hi);
      return pse_pkg::OPERATION_W'($urandom_range(0, hi));
   endfunction

   // Idle share in percent: sender 25 / receiver 58, then swapped, then none
   function automatic int idle_pct(bit sender);
      if (req_count < token_total / 3)
         return sender ? 25 : 58;
      else if (req_count < 2 * token_total / 3)
         return sender ? 58 : 25;
      return 0;
   endfunction

   // Driver: hold an offered word until taken, otherwise offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (word_taken)
            void'(token_q.pop_front());
         if (!(req.valid && !word_taken)) begin
            if (token_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
               req.valid     <= 1'b1;
               req.kind      <= token_q[0].kind;
               req.number    <= token_q[0].number;
               req.operation <= token_q[0].operation;
               req.start_req <= token_q[0].start_req;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off to back the block up
   int  hold_left = 0;
   bit  held_once = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (!held_once && rsp_count >= HOLD_AFTER) begin
         held_once = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   // Monitor: predict on each accepted token, check each accepted result
   always @(posedge clock) begin
      token_type      t;
      stack_view_type want;
      word_taken <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            t.kind      = req.kind;
            t.number    = req.number;
            t.operation = req.operation;
            t.start_req = req.start_req;
            result_q.push_back(eval_token(t));
            req_count++;
         end
         if (rsp.valid && rsp.ready) begin
            rsp_count++;
            if (result_q.size() == 0) begin
               $error("unexpected result word: top_value %0d depth %0d status %0d",
                      $signed(rsp.top_value), rsp.depth, rsp.status);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp.top_value !== want.top_value) begin
                  $error("top_value: expected %0d, got %0d",
                         $signed(want.top_value), $signed(rsp.top_value));
                  fail_count++;
               end
               if (rsp.depth !== want.depth) begin
                  $error("depth: expected %0d, got %0d", want.depth, rsp.depth);
                  fail_count++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fail_count++;
               end
            end
         end
         // Watchdog on cycles with no word moving on either side
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** postfix_stack_evaluator: FAILED **");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int pick;
      req.valid     = 1'b0;
      req.kind      = pse_pkg::KIND_NUMBER;
      req.number    = '0;
      req.operation = pse_pkg::OP_ADD;
      req.start_req = 1'b0;
      rsp.ready     = 1'b0;

      // Directed: operator on an empty stack, wrap on add, too few operands
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_ADD, 1'b1);
      add_token(pse_pkg::KIND_NUMBER, 32'h7fff_ffff, pse_pkg::OP_ADD, 1'b1);
      add_token(pse_pkg::KIND_NUMBER, 32'h8000_0000, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_SUB, 1'b0);
      // Most negative divided by minus one, then divide by zero
      add_token(pse_pkg::KIND_NUMBER, 32'h8000_0000, pse_pkg::OP_ADD, 1'b1);
      add_token(pse_pkg::KIND_NUMBER, 32'hffff_ffff, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'hffff_ffff, pse_pkg::OP_DIV, 1'b0);
      add_token(pse_pkg::KIND_NUMBER, 32'h0, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_DIV, 1'b0);
      // Unused operator codes leave the stack alone
      for (int c = pse_pkg::OP_POW + 1; c < (1 << pse_pkg::OPERATION_W); c++)
         add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OPERATION_W'(c), 1'b0);
      // Power: negative exponent, zero exponent, largest exponent
      add_token(pse_pkg::KIND_NUMBER, 32'd3, pse_pkg::OP_ADD, 1'b1);
      add_token(pse_pkg::KIND_NUMBER, 32'hffff_fffe, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_POW, 1'b0);
      add_token(pse_pkg::KIND_NUMBER, 32'h0, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_POW, 1'b0);
      add_token(pse_pkg::KIND_NUMBER, 32'd3, pse_pkg::OP_ADD, 1'b1);
      add_token(pse_pkg::KIND_NUMBER, 32'h7fff_ffff, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_POW, 1'b0);
      add_token(pse_pkg::KIND_NUMBER, 32'd7, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_MUL, 1'b0);
      add_token(pse_pkg::KIND_NUMBER, 32'd5, pse_pkg::OP_ADD, 1'b0);
      add_token(pse_pkg::KIND_OPERATOR, 32'h0, pse_pkg::OP_SUB, 1'b0);

      // Random: mostly well-formed expressions, some stack fills, some noise
      while (token_q.size() < TOKEN_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            add_token(pse_pkg::KIND_NUMBER, rand_value(), rand_op(7), 1'b1);
            repeat ($urandom_range(2, 14)) begin
               if (gen_depth < 2 || (gen_depth < STK_N && $urandom_range(0, 99) < 45))
                  add_token(pse_pkg::KIND_NUMBER, rand_value(), rand_op(7), 1'b0);
               else
                  add_token(pse_pkg::KIND_OPERATOR, $urandom, rand_op(pse_pkg::OP_POW),
                            1'b0);
            end
         end else if (pick < 78) begin
            // Fill the stack and push past the top
            add_token(pse_pkg::KIND_NUMBER, rand_value(), rand_op(7), 1'b1);
            repeat ($urandom_range(STK_N, STK_N + 3))
               add_token(pse_pkg::KIND_NUMBER, rand_value(), rand_op(7), 1'b0);
            repeat ($urandom_range(1, 6))
               add_token(pse_pkg::KIND_OPERATOR, $urandom, rand_op(pse_pkg::OP_POW), 1'b0);
         end else begin
            repeat ($urandom_range(1, 4))
               add_token(1'($urandom_range(0, 1)), $urandom, rand_op(7),
                         $urandom_range(0, 99) < 15);
         end
      end
      token_total = token_q.size();

      // Hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (req_count == token_total && result_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** postfix_stack_evaluator: PASSED **");
      else
         $display("** postfix_stack_evaluator: FAILED **");
      $finish;
   end

endmodule
